### design/csra_pkg.sv
// ----------------------------------------------------------------------------
// csra_pkg: shared types and constants for the sparse CSR matrix adder
// Field widths, action and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package csra_pkg;

  // item field widths
  localparam int ACTION_W   = 3;
  localparam int SLOT_W     = 9;
  localparam int COL_W      = 6;
  localparam int VALUE_W    = 32;
  localparam int RS_IN_W    = 9;
  localparam int RS_OUT_W   = 10;
  localparam int COUNT_W    = 10;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int ROWS_CFG_W = 7;
  localparam int NNZ_CFG_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NNZ_A        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NNZ_B        = 3'd3;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD_A_ELEM = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_A_ROW  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B_ELEM = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B_ROW  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RUN         = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ_C_ELEM = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_READ_C_ROW  = 3'd6;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_SPAN0,
    S_SPAN1,
    S_SPAN2,
    S_MERGE,
    S_FILL
  } state_t;

endpackage

### design/csra_if.sv
// ----------------------------------------------------------------------------
// csra_if: channel interfaces for the sparse CSR matrix adder
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface csra_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [csra_pkg::ACTION_W-1:0] action;
  logic        [csra_pkg::SLOT_W-1:0]   slot;
  logic        [csra_pkg::COL_W-1:0]    column_in;
  logic signed [csra_pkg::VALUE_W-1:0]  value_in;
  logic        [csra_pkg::RS_IN_W-1:0]  row_start_in;

  modport source (output valid, action, slot, column_in, value_in, row_start_in,
                  input ready);
  modport sink   (input valid, action, slot, column_in, value_in, row_start_in,
                  output ready);
endinterface

interface csra_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [csra_pkg::VALUE_W-1:0]  value_out;
  logic        [csra_pkg::COL_W-1:0]    column_out;
  logic        [csra_pkg::RS_OUT_W-1:0] row_start_out;
  logic        [csra_pkg::COUNT_W-1:0]  result_count;

  modport source (output valid, value_out, column_out, row_start_out, result_count,
                  input ready);
  modport sink   (input valid, value_out, column_out, row_start_out, result_count,
                  output ready);
endinterface

interface csra_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [csra_pkg::CFG_IDX_W-1:0]     index;
  logic [csra_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/csra_ram.sv
// ----------------------------------------------------------------------------
// csra_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module csra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/sparse_csr_matrix_add.sv
// A load item answers in the cycle after acceptance; a read item goes through S_RDATA
// and then the result register. A run item passes S_SPAN0, S_SPAN1 and S_SPAN2 for
// each row in use, an S_MERGE step per merged pair or single element, S_FILL for each
// row from row_count up to MAX_ROWS. One item at a time; the merge uses one adder.
// Reset clears the sequencer, the registers and the C count; element stores and
// row-start tables are not cleared and hold nothing valid until written.
// ----------------------------------------------------------------------------
// sparse_csr_matrix_add: adds two sparse matrices held in CSR form
// Loads A/B stores, merges them row by row into C, and reads C back.
// ----------------------------------------------------------------------------
module sparse_csr_matrix_add #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_NONZEROS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  csra_in_if.sink       in_ch,
  csra_out_if.source    out_ch,
  csra_cfg_if.sink      cfg_ch
);
  localparam int C_DEPTH = 2 * MAX_NONZEROS;
  localparam int RAW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW     = $clog2(MAX_ROWS + 1);
  localparam int EAW     = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int PW      = $clog2(MAX_NONZEROS + 1);
  localparam int CAW     = $clog2(C_DEPTH);
  localparam int CCW     = $clog2(C_DEPTH + 1);
  localparam int VW      = csra_pkg::VALUE_W;
  localparam int CW      = csra_pkg::COL_W;
  localparam int ELEM_W  = VW + CW;

  // configuration registers
  logic [csra_pkg::ROWS_CFG_W-1:0] row_count_r;
  logic [csra_pkg::NNZ_CFG_W-1:0]  nnz_a_r;
  logic [csra_pkg::NNZ_CFG_W-1:0]  nnz_b_r;

  // sequencer and datapath state
  csra_pkg::state_t state_r, state_nxt;
  logic [RCW-1:0]   row_r, row_nxt;
  logic [PW-1:0]    pa_r, pa_nxt, pb_r, pb_nxt;
  logic [PW-1:0]    ea_r, ea_nxt, eb_r, eb_nxt;
  logic [PW-1:0]    lo_a_r, lo_a_nxt, lo_b_r, lo_b_nxt;
  logic [CCW-1:0]   c_count_r, c_count_nxt;
  logic             rd_ok_r, rd_ok_nxt, rd_elem_r, rd_elem_nxt;

  // result register
  logic                                 out_valid_r, out_valid_nxt;
  logic [VW-1:0]                        out_value_r, out_value_nxt;
  logic [CW-1:0]                        out_col_r, out_col_nxt;
  logic [csra_pkg::RS_OUT_W-1:0]        out_rs_r, out_rs_nxt;
  logic [csra_pkg::COUNT_W-1:0]         out_count_r, out_count_nxt;

  logic in_ready, in_fire;
  logic [RCW-1:0] rows_lim, row_p1;
  logic [PW-1:0]  na_lim, nb_lim, clamp_a, clamp_b, hi_a, hi_b;
  logic [RAW-1:0] row_addr;

  // memory ports
  logic                        a_elem_we, b_elem_we, a_row_we, b_row_we;
  logic [ELEM_W-1:0]           a_elem_rd, b_elem_rd, c_elem_rd;
  logic [csra_pkg::RS_IN_W-1:0] a_row_rd, b_row_rd;
  logic                        c_elem_we, c_row_we;
  logic [ELEM_W-1:0]           c_elem_wd;
  logic [CCW-1:0]              c_row_rd;

  // merge datapath
  logic          a_ok, b_ok;
  logic [CW-1:0] a_col, b_col;
  logic [VW-1:0] a_val, b_val, sum;

  assign in_fire = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.value_out     = out_value_r;
  assign out_ch.column_out    = out_col_r;
  assign out_ch.row_start_out = out_rs_r;
  assign out_ch.result_count  = out_count_r;

  // configuration writes; column count does not affect the merge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= csra_pkg::ROWS_CFG_W'(1);
      nnz_a_r     <= '0;
      nnz_b_r     <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        csra_pkg::CFG_ROW_COUNT: row_count_r <= cfg_ch.data[csra_pkg::ROWS_CFG_W-1:0];
        csra_pkg::CFG_NNZ_A:     nnz_a_r <= cfg_ch.data;
        csra_pkg::CFG_NNZ_B:     nnz_b_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // clamped limits
  assign rows_lim = (32'(row_count_r) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(row_count_r);
  assign na_lim = (32'(nnz_a_r) > 32'(MAX_NONZEROS)) ? PW'(MAX_NONZEROS) : PW'(nnz_a_r);
  assign nb_lim = (32'(nnz_b_r) > 32'(MAX_NONZEROS)) ? PW'(MAX_NONZEROS) : PW'(nnz_b_r);
  assign row_p1 = row_r + 1'b1;

  // row starts clamped to the element count
  assign clamp_a = (32'(a_row_rd) > 32'(na_lim)) ? na_lim : PW'(a_row_rd);
  assign clamp_b = (32'(b_row_rd) > 32'(nb_lim)) ? nb_lim : PW'(b_row_rd);
  assign hi_a = (row_p1 < rows_lim) ? clamp_a : na_lim;
  assign hi_b = (row_p1 < rows_lim) ? clamp_b : nb_lim;

  // load decode
  assign a_elem_we = in_fire && in_ch.action == csra_pkg::ACT_LOAD_A_ELEM
                     && 32'(in_ch.slot) < 32'(MAX_NONZEROS);
  assign b_elem_we = in_fire && in_ch.action == csra_pkg::ACT_LOAD_B_ELEM
                     && 32'(in_ch.slot) < 32'(MAX_NONZEROS);
  assign a_row_we  = in_fire && in_ch.action == csra_pkg::ACT_LOAD_A_ROW
                     && 32'(in_ch.slot) < 32'(MAX_ROWS);
  assign b_row_we  = in_fire && in_ch.action == csra_pkg::ACT_LOAD_B_ROW
                     && 32'(in_ch.slot) < 32'(MAX_ROWS);

  csra_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_NONZEROS)) u_a_elem (
    .clk(clk), .we(a_elem_we), .waddr(EAW'(in_ch.slot)),
    .wdata({in_ch.column_in, in_ch.value_in}),
    .raddr(pa_nxt[EAW-1:0]), .rdata(a_elem_rd)
  );

  csra_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_NONZEROS)) u_b_elem (
    .clk(clk), .we(b_elem_we), .waddr(EAW'(in_ch.slot)),
    .wdata({in_ch.column_in, in_ch.value_in}),
    .raddr(pb_nxt[EAW-1:0]), .rdata(b_elem_rd)
  );

  csra_ram #(.WIDTH(csra_pkg::RS_IN_W), .DEPTH(MAX_ROWS)) u_a_row (
    .clk(clk), .we(a_row_we), .waddr(RAW'(in_ch.slot)), .wdata(in_ch.row_start_in),
    .raddr(row_addr), .rdata(a_row_rd)
  );

  csra_ram #(.WIDTH(csra_pkg::RS_IN_W), .DEPTH(MAX_ROWS)) u_b_row (
    .clk(clk), .we(b_row_we), .waddr(RAW'(in_ch.slot)), .wdata(in_ch.row_start_in),
    .raddr(row_addr), .rdata(b_row_rd)
  );

  csra_ram #(.WIDTH(ELEM_W), .DEPTH(C_DEPTH)) u_c_elem (
    .clk(clk), .we(c_elem_we), .waddr(c_count_r[CAW-1:0]), .wdata(c_elem_wd),
    .raddr(CAW'(in_ch.slot)), .rdata(c_elem_rd)
  );

  csra_ram #(.WIDTH(CCW), .DEPTH(MAX_ROWS)) u_c_row (
    .clk(clk), .we(c_row_we), .waddr(row_r[RAW-1:0]), .wdata(c_count_r),
    .raddr(RAW'(in_ch.slot)), .rdata(c_row_rd)
  );

  // shared merge unit: head compare and adder
  assign a_ok  = pa_r < ea_r;
  assign b_ok  = pb_r < eb_r;
  assign a_val = a_elem_rd[VW-1:0];
  assign b_val = b_elem_rd[VW-1:0];
  assign a_col = a_elem_rd[ELEM_W-1 -: CW];
  assign b_col = b_elem_rd[ELEM_W-1 -: CW];
  assign sum   = a_val + b_val;

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csra_pkg::S_IDLE;
      c_count_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      c_count_r   <= c_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    ea_r        <= ea_nxt;
    eb_r        <= eb_nxt;
    lo_a_r      <= lo_a_nxt;
    lo_b_r      <= lo_b_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_elem_r   <= rd_elem_nxt;
    out_value_r <= out_value_nxt;
    out_col_r   <= out_col_nxt;
    out_rs_r    <= out_rs_nxt;
    out_count_r <= out_count_nxt;
  end

  // next state and control
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    lo_a_nxt      = lo_a_r;
    lo_b_nxt      = lo_b_r;
    c_count_nxt   = c_count_r;
    rd_ok_nxt     = rd_ok_r;
    rd_elem_nxt   = rd_elem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_col_nxt   = out_col_r;
    out_rs_nxt    = out_rs_r;
    out_count_nxt = out_count_r;
    row_addr      = row_r[RAW-1:0];
    c_elem_we     = 1'b0;
    c_elem_wd     = {a_col, a_val};
    c_row_we      = 1'b0;
    in_ready      = 1'b0;

    unique case (state_r)
      csra_pkg::S_IDLE: begin
        in_ready = !out_valid_r || out_ch.ready;
        if (in_fire) begin
          unique case (in_ch.action)
            csra_pkg::ACT_RUN: begin
              row_nxt     = '0;
              c_count_nxt = '0;
              state_nxt   = (rows_lim == '0) ? csra_pkg::S_FILL : csra_pkg::S_SPAN0;
            end
            csra_pkg::ACT_READ_C_ELEM: begin
              rd_elem_nxt = 1'b1;
              rd_ok_nxt   = 32'(in_ch.slot) < 32'(c_count_r);
              state_nxt   = csra_pkg::S_RDATA;
            end
            csra_pkg::ACT_READ_C_ROW: begin
              rd_elem_nxt = 1'b0;
              rd_ok_nxt   = 32'(in_ch.slot) < 32'(MAX_ROWS);
              state_nxt   = csra_pkg::S_RDATA;
            end
            default: begin
              // loads and the unused code answer directly from IDLE
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_col_nxt   = '0;
              out_rs_nxt    = '0;
              out_count_nxt = csra_pkg::COUNT_W'(c_count_r);
            end
          endcase
        end
      end

      csra_pkg::S_RDATA: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = (rd_ok_r && rd_elem_r) ? c_elem_rd[VW-1:0] : '0;
        out_col_nxt   = (rd_ok_r && rd_elem_r) ? c_elem_rd[ELEM_W-1 -: CW] : '0;
        out_rs_nxt    = (rd_ok_r && !rd_elem_r) ? csra_pkg::RS_OUT_W'(c_row_rd) : '0;
        out_count_nxt = csra_pkg::COUNT_W'(c_count_r);
        state_nxt     = csra_pkg::S_IDLE;
      end

      // read this row's starts
      csra_pkg::S_SPAN0: begin
        state_nxt = csra_pkg::S_SPAN1;
      end

      // latch row begin, read next row's starts
      csra_pkg::S_SPAN1: begin
        lo_a_nxt  = clamp_a;
        lo_b_nxt  = clamp_b;
        row_addr  = row_p1[RAW-1:0];
        state_nxt = csra_pkg::S_SPAN2;
      end

      // row end, record C row start, fetch first heads
      csra_pkg::S_SPAN2: begin
        ea_nxt   = (hi_a < lo_a_r) ? lo_a_r : hi_a;
        eb_nxt   = (hi_b < lo_b_r) ? lo_b_r : hi_b;
        pa_nxt   = lo_a_r;
        pb_nxt   = lo_b_r;
        c_row_we = 1'b1;
        if ((lo_a_r < ea_nxt) || (lo_b_r < eb_nxt)) begin
          state_nxt = csra_pkg::S_MERGE;
        end else begin
          row_nxt   = row_p1;
          state_nxt = (row_p1 < rows_lim) ? csra_pkg::S_SPAN0 : csra_pkg::S_FILL;
        end
      end

      // one merge step per cycle
      csra_pkg::S_MERGE: begin
        if (a_ok && b_ok && a_col == b_col) begin
          c_elem_wd = {a_col, sum};
          c_elem_we = (sum != '0);
          pa_nxt    = pa_r + 1'b1;
          pb_nxt    = pb_r + 1'b1;
        end else if (!b_ok || (a_ok && a_col < b_col)) begin
          c_elem_wd = {a_col, a_val};
          c_elem_we = 1'b1;
          pa_nxt    = pa_r + 1'b1;
        end else begin
          c_elem_wd = {b_col, b_val};
          c_elem_we = 1'b1;
          pb_nxt    = pb_r + 1'b1;
        end
        // C store full: drop the element
        if (32'(c_count_r) >= 32'(C_DEPTH)) begin
          c_elem_we = 1'b0;
        end
        if (c_elem_we) begin
          c_count_nxt = c_count_r + 1'b1;
        end
        if (!((pa_nxt < ea_r) || (pb_nxt < eb_r))) begin
          row_nxt   = row_p1;
          state_nxt = (row_p1 < rows_lim) ? csra_pkg::S_SPAN0 : csra_pkg::S_FILL;
        end
      end

      // unused rows get the final count
      csra_pkg::S_FILL: begin
        if (32'(row_r) < 32'(MAX_ROWS)) begin
          c_row_we = 1'b1;
          row_nxt  = row_p1;
        end else begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_col_nxt   = '0;
          out_rs_nxt    = '0;
          out_count_nxt = csra_pkg::COUNT_W'(c_count_r);
          state_nxt     = csra_pkg::S_IDLE;
        end
      end

      default: state_nxt = csra_pkg::S_IDLE;
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(c_count_r) <= 32'(C_DEPTH))
    else $error("C count beyond store depth");

  a_merge_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == csra_pkg::S_MERGE |-> (a_ok || b_ok))
    else $error("merge step with both rows exhausted");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == csra_pkg::S_MERGE |-> (pa_r <= ea_r) && (pb_r <= eb_r))
    else $error("merge pointer past row end");

  a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r || state_r != csra_pkg::S_IDLE))
    else $error("accepted item gave no result and no work");

endmodule

### test/sparse_csr_matrix_add_test.sv
// ----------------------------------------------------------------------------
// sparse_csr_matrix_add_test: self-checking bench for the sparse CSR adder
// Loads CSR matrices, runs the merge, reads C back and compares each result
// item against a built-in model of the adder. The sender works in bursts and
// the receiver stalls on patterns.
// ----------------------------------------------------------------------------
module sparse_csr_matrix_add_test;

  localparam int ROWS_MAX  = 64;
  localparam int ELEMS_MAX = 256;
  localparam int C_MAX     = 512;
  localparam int QUIET_LIMIT = 20000;
  localparam logic [csra_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;

  typedef struct {
    logic [csra_pkg::ACTION_W-1:0] action;
    logic [csra_pkg::SLOT_W-1:0]   slot;
    logic [csra_pkg::COL_W-1:0]    col;
    logic [csra_pkg::VALUE_W-1:0]  val;
    logic [csra_pkg::RS_IN_W-1:0]  rs;
  } csr_item_t;

  typedef struct {
    logic [csra_pkg::VALUE_W-1:0]  val;
    logic [csra_pkg::COL_W-1:0]    col;
    logic [csra_pkg::RS_OUT_W-1:0] rs;
    logic [csra_pkg::COUNT_W-1:0]  cnt;
  } csr_result_t;

  typedef struct {
    csr_item_t   it;
    bit          fixed;
    csr_result_t res;
  } directed_row_t;

  logic clk;
  logic rst_n;

  csra_in_if  in_ch ();
  csra_out_if out_ch ();
  csra_cfg_if cfg_ch ();

  sparse_csr_matrix_add i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // adder image: registers and stores
  int unsigned                   m_rows, m_cols, m_nnz_a, m_nnz_b;
  logic [csra_pkg::VALUE_W-1:0]  m_a_val [ELEMS_MAX];
  logic [csra_pkg::COL_W-1:0]    m_a_col [ELEMS_MAX];
  logic [csra_pkg::RS_IN_W-1:0]  m_a_rs  [ROWS_MAX];
  logic [csra_pkg::VALUE_W-1:0]  m_b_val [ELEMS_MAX];
  logic [csra_pkg::COL_W-1:0]    m_b_col [ELEMS_MAX];
  logic [csra_pkg::RS_IN_W-1:0]  m_b_rs  [ROWS_MAX];
  logic [csra_pkg::VALUE_W-1:0]  m_c_val [C_MAX];
  logic [csra_pkg::COL_W-1:0]    m_c_col [C_MAX];
  logic [csra_pkg::RS_OUT_W-1:0] m_c_rs  [ROWS_MAX];
  int unsigned                   m_c_cnt;

  csr_result_t pending_results[$];
  directed_row_t directed_rows[$];

  int errors;
  int items_sent;
  int results_seen;
  int runs_sent;
  int burst_left;
  int quiet;
  int ready_mode;
  int cycle_no;
  bit stores_filled;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mismatch report
  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  // merge span of one row, saturated at the element count
  function automatic void row_span(input logic [csra_pkg::RS_IN_W-1:0] starts [ROWS_MAX],
                                   input int unsigned r, input int unsigned rows,
                                   input int unsigned nnz,
                                   output int unsigned lo, output int unsigned hi);
    int unsigned s, e;
    s = (starts[r] > nnz) ? nnz : starts[r];
    e = (r + 1 < rows) ? ((starts[r+1] > nnz) ? nnz : starts[r+1]) : nnz;
    lo = s;
    hi = (e < s) ? s : e;
  endfunction

  function automatic void push_c(logic [csra_pkg::VALUE_W-1:0] v,
                                 logic [csra_pkg::COL_W-1:0] c);
    if (m_c_cnt < C_MAX) begin
      m_c_val[m_c_cnt] = v;
      m_c_col[m_c_cnt] = c;
      m_c_cnt++;
    end
  endfunction

  // C = A + B, row by row in column order, zero sums dropped
  function automatic void merge_matrices();
    int unsigned rows, na, nb, r, pa, ea, pb, eb;
    logic [csra_pkg::VALUE_W-1:0] s;
    rows = (m_rows > ROWS_MAX) ? ROWS_MAX : m_rows;
    na = (m_nnz_a > ELEMS_MAX) ? ELEMS_MAX : m_nnz_a;
    nb = (m_nnz_b > ELEMS_MAX) ? ELEMS_MAX : m_nnz_b;
    m_c_cnt = 0;
    for (r = 0; r < rows; r++) begin
      row_span(m_a_rs, r, rows, na, pa, ea);
      row_span(m_b_rs, r, rows, nb, pb, eb);
      m_c_rs[r] = csra_pkg::RS_OUT_W'(m_c_cnt);
      while (pa < ea || pb < eb) begin
        if (pa < ea && pb < eb && m_a_col[pa] == m_b_col[pb]) begin
          s = m_a_val[pa] + m_b_val[pb];
          if (s != '0) push_c(s, m_a_col[pa]);
          pa++;
          pb++;
        end else if (pb >= eb || (pa < ea && m_a_col[pa] < m_b_col[pb])) begin
          push_c(m_a_val[pa], m_a_col[pa]);
          pa++;
        end else begin
          push_c(m_b_val[pb], m_b_col[pb]);
          pb++;
        end
      end
    end
    for (; r < ROWS_MAX; r++) m_c_rs[r] = csra_pkg::RS_OUT_W'(m_c_cnt);
  endfunction

  // update the image for one item and return its result
  function automatic csr_result_t apply_item(csr_item_t it);
    csr_result_t res;
    res = '{default: '0};
    case (it.action)
      csra_pkg::ACT_LOAD_A_ELEM: if (it.slot < ELEMS_MAX) begin
        m_a_val[it.slot] = it.val;
        m_a_col[it.slot] = it.col;
      end
      csra_pkg::ACT_LOAD_A_ROW: if (it.slot < ROWS_MAX) m_a_rs[it.slot] = it.rs;
      csra_pkg::ACT_LOAD_B_ELEM: if (it.slot < ELEMS_MAX) begin
        m_b_val[it.slot] = it.val;
        m_b_col[it.slot] = it.col;
      end
      csra_pkg::ACT_LOAD_B_ROW: if (it.slot < ROWS_MAX) m_b_rs[it.slot] = it.rs;
      csra_pkg::ACT_RUN: merge_matrices();
      csra_pkg::ACT_READ_C_ELEM: if (it.slot < m_c_cnt) begin
        res.val = m_c_val[it.slot];
        res.col = m_c_col[it.slot];
      end
      csra_pkg::ACT_READ_C_ROW: if (it.slot < ROWS_MAX) res.rs = m_c_rs[it.slot];
      default: ;
    endcase
    res.cnt = csra_pkg::COUNT_W'(m_c_cnt);
    return res;
  endfunction

  // send one item; bursts with random gaps in between
  task automatic send_item(csr_item_t it, bit fixed = 0,
                           csr_result_t fixed_res = '{default: '0});
    csr_result_t res;
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.slot         <= it.slot;
    in_ch.column_in    <= it.col;
    in_ch.value_in     <= it.val;
    in_ch.row_start_in <= it.rs;
    do @(posedge clk); while (!in_ch.ready);
    res = apply_item(it);
    pending_results.push_back(fixed ? fixed_res : res);
    items_sent++;
    burst_left--;
    if (it.action == csra_pkg::ACT_RUN) runs_sent++;
  endtask

  // stop sending and wait until every expected result is in
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [csra_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data[csra_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      csra_pkg::CFG_ROW_COUNT:    m_rows  = data & 7'h7f;
      csra_pkg::CFG_COLUMN_COUNT: m_cols  = data & 7'h7f;
      csra_pkg::CFG_NNZ_A:        m_nnz_a = data & 9'h1ff;
      csra_pkg::CFG_NNZ_B:        m_nnz_b = data & 9'h1ff;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [csra_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic csr_item_t make_item(logic [csra_pkg::ACTION_W-1:0] act,
                                          int unsigned slot, int unsigned col,
                                          logic [csra_pkg::VALUE_W-1:0] val,
                                          int unsigned rs);
    csr_item_t it;
    it.action = act;
    it.slot   = csra_pkg::SLOT_W'(slot);
    it.col    = csra_pkg::COL_W'(col);
    it.val    = val;
    it.rs     = csra_pkg::RS_IN_W'(rs);
    return it;
  endfunction

  // noise: any action with random fields; only safe once every store is written
  task automatic send_noise();
    csr_item_t it;
    it.action = csra_pkg::ACTION_W'($urandom_range(0, 7));
    it.slot   = csra_pkg::SLOT_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(0, 70));
    it.col    = csra_pkg::COL_W'($urandom);
    it.val    = pick_value();
    it.rs     = csra_pkg::RS_IN_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 511)
                                                               : $urandom_range(0, 260));
    send_item(it);
  endtask

  task automatic maybe_noise();
    if (stores_filled && $urandom_range(0, 9) == 0) send_noise();
  endtask

  // one well-formed matrix pair, loaded, merged and read back
  task automatic matrix_phase(int unsigned rows_cfg, int unsigned cols_cfg,
                              int unsigned na_cfg, int unsigned nb_cfg,
                              bit broken, int unsigned reads);
    int unsigned rows, na, nb, r, e, col, cnt, slot;
    int unsigned st_a[ROWS_MAX+1];
    int unsigned st_b[ROWS_MAX+1];
    logic [csra_pkg::VALUE_W-1:0] a_at[int];
    logic [csra_pkg::VALUE_W-1:0] v;
    drain_results();
    write_reg(csra_pkg::CFG_ROW_COUNT, rows_cfg);
    write_reg(csra_pkg::CFG_COLUMN_COUNT, cols_cfg);
    write_reg(csra_pkg::CFG_NNZ_A, na_cfg);
    write_reg(csra_pkg::CFG_NNZ_B, nb_cfg);
    rows = ((rows_cfg & 7'h7f) > ROWS_MAX) ? ROWS_MAX : (rows_cfg & 7'h7f);
    na = ((na_cfg & 9'h1ff) > ELEMS_MAX) ? ELEMS_MAX : (na_cfg & 9'h1ff);
    nb = ((nb_cfg & 9'h1ff) > ELEMS_MAX) ? ELEMS_MAX : (nb_cfg & 9'h1ff);
    if (rows > 0) begin
      for (r = 0; r <= rows; r++) begin
        st_a[r] = (r * na + rows - 1) / rows;
        st_b[r] = (r * nb + rows - 1) / rows;
      end
    end
    // A elements and row starts
    for (r = 0; r < rows; r++) begin
      col = $urandom_range(0, 2);
      for (e = st_a[r]; e < st_a[r+1]; e++) begin
        v = pick_value();
        a_at[r * 64 + (col % 64)] = v;
        send_item(make_item(csra_pkg::ACT_LOAD_A_ELEM, e, col % 64, v, $urandom));
        maybe_noise();
        col += $urandom_range(1, 3);
      end
      send_item(make_item(csra_pkg::ACT_LOAD_A_ROW, r, $urandom, $urandom,
                          broken && $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                              : st_a[r]));
    end
    // B elements, often cancelling A at the same position
    for (r = 0; r < rows; r++) begin
      col = $urandom_range(0, 2);
      for (e = st_b[r]; e < st_b[r+1]; e++) begin
        v = pick_value();
        if (a_at.exists(r * 64 + (col % 64))) begin
          if ($urandom_range(0, 2) == 0) v = -a_at[r * 64 + (col % 64)];
        end
        send_item(make_item(csra_pkg::ACT_LOAD_B_ELEM, e, col % 64, v, $urandom));
        maybe_noise();
        col += $urandom_range(1, 3);
      end
      send_item(make_item(csra_pkg::ACT_LOAD_B_ROW, r, $urandom, $urandom,
                          broken && $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                              : st_b[r]));
    end
    send_item(make_item(csra_pkg::ACT_RUN, $urandom, $urandom, $urandom, $urandom));
    stores_filled |= (na == ELEMS_MAX && nb == ELEMS_MAX && rows == ROWS_MAX);
    // read back C elements, row starts and some out-of-range slots
    cnt = m_c_cnt;
    for (e = 0; e < reads; e++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          slot = (cnt > 0 && e < cnt) ? e : $urandom_range(0, cnt + 3);
          send_item(make_item(csra_pkg::ACT_READ_C_ELEM, slot, $urandom, $urandom,
                              $urandom));
        end
        3, 4: send_item(make_item(csra_pkg::ACT_READ_C_ROW, $urandom_range(0, 63),
                                  $urandom, $urandom, $urandom));
        default: send_item(make_item($urandom_range(0, 1) ? csra_pkg::ACT_READ_C_ELEM
                                                          : csra_pkg::ACT_READ_C_ROW,
                                     $urandom_range(0, 511), $urandom, $urandom,
                                     $urandom));
      endcase
      maybe_noise();
    end
  endtask

  function automatic void add_directed(csr_item_t it, bit fixed);
    directed_row_t d;
    d.it = it;
    d.fixed = fixed;
    d.res = '{default: '0};
    directed_rows.push_back(d);
  endfunction

  // result checker
  always @(posedge clk) begin
    csr_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("MISMATCH unexpected result item %0d", results_seen);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value_out !== want.val)
          report("value_out", out_ch.value_out, want.val);
        if (out_ch.column_out !== want.col)
          report("column_out", out_ch.column_out, want.col);
        if (out_ch.row_start_out !== want.rs)
          report("row_start_out", out_ch.row_start_out, want.rs);
        if (out_ch.result_count !== want.cnt)
          report("result_count", out_ch.result_count, want.cnt);
      end
    end
  end

  // receiver stall patterns, switched periodically at random
  always @(negedge clk) begin
    cycle_no++;
    if (cycle_no % 300 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      2: out_ch.ready <= (cycle_no % 5 != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("sparse_csr_matrix_add verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    directed_row_t d;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    runs_sent = 0;
    burst_left = 0;
    quiet = 0;
    ready_mode = 0;
    cycle_no = 0;
    stores_filled = 0;
    m_rows = 1;
    m_cols = 1;
    m_nnz_a = 0;
    m_nnz_b = 0;
    m_c_cnt = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = csra_pkg::ACT_LOAD_A_ELEM;
    in_ch.slot = '0;
    in_ch.column_in = '0;
    in_ch.value_in = '0;
    in_ch.row_start_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = csra_pkg::CFG_ROW_COUNT;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset defaults, ignored slots, unused action, empty merge
    add_directed(make_item(csra_pkg::ACT_READ_C_ELEM, 0, 0, 0, 0), 1);
    add_directed(make_item(ACT_UNUSED, 511, 63, 32'hffff_ffff, 511), 1);
    add_directed(make_item(csra_pkg::ACT_LOAD_A_ROW, 0, 0, 0, 0), 1);
    add_directed(make_item(csra_pkg::ACT_LOAD_B_ROW, 0, 63, 0, 256), 1);
    add_directed(make_item(csra_pkg::ACT_LOAD_A_ELEM, 300, 63, 32'h8000_0000, 0), 1);
    add_directed(make_item(csra_pkg::ACT_LOAD_B_ELEM, 511, 0, 32'h7fff_ffff, 0), 1);
    add_directed(make_item(csra_pkg::ACT_LOAD_A_ROW, 100, 0, 0, 511), 1);
    add_directed(make_item(csra_pkg::ACT_LOAD_B_ROW, 64, 0, 0, 1), 1);
    add_directed(make_item(csra_pkg::ACT_LOAD_A_ELEM, 255, 63, 32'h7fff_ffff, 0), 0);
    add_directed(make_item(csra_pkg::ACT_LOAD_B_ELEM, 0, 0, 32'h8000_0000, 0), 0);
    add_directed(make_item(csra_pkg::ACT_RUN, 0, 0, 0, 0), 1);
    add_directed(make_item(csra_pkg::ACT_READ_C_ROW, 0, 0, 0, 0), 1);
    add_directed(make_item(csra_pkg::ACT_READ_C_ROW, 63, 0, 0, 0), 1);
    add_directed(make_item(csra_pkg::ACT_READ_C_ROW, 511, 0, 0, 0), 1);
    add_directed(make_item(csra_pkg::ACT_READ_C_ELEM, 511, 0, 0, 0), 1);
    add_directed(make_item(ACT_UNUSED, 0, 0, 0, 0), 1);
    foreach (directed_rows[k]) begin
      d = directed_rows[k];
      send_item(d.it, d.fixed, d.res);
    end

    // full-size extreme first, so every store is written from here on
    matrix_phase(127, 127, 511, 511, 0, 30);
    matrix_phase(64, 64, 24, 24, 1, 16);
    matrix_phase(1, 1, 0, 0, 0, 10);
    matrix_phase(1, 64, 40, 40, 0, 30);
    matrix_phase(64, 0, 0, 16, 0, 10);
    matrix_phase(0, 127, 0, 0, 0, 10);
    while (items_sent < 1250) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
      end
      matrix_phase($urandom_range(1, 12), $urandom_range(0, 127), $urandom_range(0, 30),
                   $urandom_range(0, 30), $urandom_range(0, 4) == 0, 14);
    end

    drain_results();
    repeat (800) @(posedge clk);
    $display("covered %0d items, %0d merge runs, %0d result items checked",
             items_sent, runs_sent, results_seen);
    $display("matrix shapes from zero rows to %0d rows, element counts up to %0d",
             ROWS_MAX, ELEMS_MAX);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("sparse_csr_matrix_add verification clean");
    end else begin
      $display("sparse_csr_matrix_add verification failed");
    end
    $finish;
  end

endmodule
